// File: hdl/vfs_pkg.sv
// Shared constants, codes and controller/datapath interface types for the field sampler.
package vfs_pkg;

   localparam int SPACE_BITS = 5;
   localparam int T_BITS     = 3;
   localparam int COMP_WIDTH = 16;
   localparam int FRAC_BITS  = 16;
   localparam int ADDR_BITS  = 3 * SPACE_BITS + T_BITS;
   localparam int DEPTH      = 1 << ADDR_BITS;
   localparam int POS_W      = SPACE_BITS + FRAC_BITS;
   localparam int TPOS_W     = T_BITS + FRAC_BITS;
   localparam int DT_W       = FRAC_BITS + 1;
   localparam int VEC_W      = 3 * COMP_WIDTH;
   localparam int ACC_W      = COMP_WIDTH + 3;
   localparam int DIV_K      = 22;
   localparam int RECIP_W    = 20;
   localparam logic [RECIP_W-1:0] RECIP6 = RECIP_W'(((1 << DIV_K) + 5) / 6);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int KIND_W     = 2;
   localparam int REQ_DATA_W = 152;
   localparam int RSP_DATA_W = VEC_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE  = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_RK4    = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIZE_X  = 3'd0,
      CSR_SIZE_Y  = 3'd1,
      CSR_SIZE_Z  = 3'd2,
      CSR_SIZE_T  = 3'd3,
      CSR_STEP_DT = 3'd4
   } csr_index_type;

   // Interpolation steps: four x lerps, two y lerps, one z lerp, one t lerp.
   typedef enum logic [2:0] {
      LERP_X0 = 3'd0,
      LERP_X1 = 3'd1,
      LERP_X2 = 3'd2,
      LERP_X3 = 3'd3,
      LERP_Y0 = 3'd4,
      LERP_Y1 = 3'd5,
      LERP_Z  = 3'd6,
      LERP_T  = 3'd7
   } lerp_step_type;

   typedef struct packed {
      logic          load;
      logic          wr_en;
      logic          rd_en;
      logic [2:0]    rd_idx;
      logic          cap_en;
      logic [2:0]    cap_idx;
      logic          slice;
      logic          lerp_en;
      lerp_step_type lerp_step;
      logic          acc_en;
      logic          acc_first;
      logic          acc_double;
      logic          adv_mul;
      logic          adv_upd;
      logic          adv_half;
      logic          div_mul;
      logic          div_upd;
      logic          out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// File: hdl/vfs_datapath.sv
// Datapath: field memory, corner registers, lerp lanes, RK4 advance and mean, result register.
module vfs_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  vfs_pkg::cmd_type                cmd,
   output vfs_pkg::status_type             status,
   input  logic [vfs_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [vfs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vfs_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [vfs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser
);

   localparam int SB = vfs_pkg::SPACE_BITS;
   localparam int TB = vfs_pkg::T_BITS;
   localparam int FB = vfs_pkg::FRAC_BITS;
   localparam int PW = vfs_pkg::POS_W;
   localparam int TW = vfs_pkg::TPOS_W;
   localparam int CW = vfs_pkg::COMP_WIDTH;
   localparam int DW = vfs_pkg::DT_W;
   localparam int AW = vfs_pkg::ACC_W;
   localparam int MW = CW + DW + 1;
   localparam int NW = MW + 2;
   localparam int LW = 2 * (CW + 1);
   localparam int QW = AW + vfs_pkg::RECIP_W;
   localparam logic [AW-1:0] ACC_BIAS = AW'(6 << (CW - 1));
   localparam logic [vfs_pkg::CSR_DATA_W-1:0] CSR_DATA_MAX = vfs_pkg::CSR_DATA_W'(1 << FB);

   // configuration: spatial sizes held as size minus one, time size held as is
   logic [SB-1:0]  size_m1_ff [0:2];
   logic [TB:0]    size_t_ff;
   logic [DW-1:0]  step_dt_ff;
   logic [TB-1:0]  t_m1;

   logic [PW-1:0]  q_pos_ff [0:2];
   logic [PW-1:0]  s_pos_ff [0:2];
   logic [TW-1:0]  q_t_ff;
   logic [TW-1:0]  s_t_ff;
   logic           inb_ff;

   logic [vfs_pkg::VEC_W-1:0] field_store_ff [0:vfs_pkg::DEPTH-1];
   logic [vfs_pkg::VEC_W-1:0] rdata_ff;

   logic signed [CW-1:0] corner_ff [0:7][0:2];
   logic signed [CW-1:0] slice_ff  [0:1][0:2];
   logic signed [CW-1:0] vres_ff   [0:2];
   logic signed [AW-1:0] acc_ff    [0:2];
   logic signed [MW-1:0] adv_prod_ff [0:2];
   logic        [QW-1:0] div_prod_ff [0:2];

   logic [vfs_pkg::VEC_W-1:0] out_vel_ff;
   logic                      out_inb_ff;
   logic                      out_valid_ff;

   logic [SB-1:0]  base_idx [0:2];
   logic [SB-1:0]  top_idx  [0:2];
   logic [TB-1:0]  t_base;
   logic [TB-1:0]  t_top;
   logic [vfs_pkg::ADDR_BITS-1:0] rd_addr;
   logic [PW-1:0]  req_pos [0:2];
   logic [TW-1:0]  req_t;
   logic [vfs_pkg::ADDR_BITS-1:0] wr_addr;
   logic           req_inb;

   logic [FB-1:0]         lerp_f;
   logic signed [CW-1:0]  lerp_a [0:2];
   logic signed [CW-1:0]  lerp_b [0:2];
   logic signed [CW-1:0]  lerp_r [0:2];
   logic signed [CW:0]    lerp_d [0:2];
   logic signed [LW-1:0]  lerp_p [0:2];

   logic [PW-1:0]         adv_pos [0:2];
   logic [TW-1:0]         adv_t;
   logic [AW-1:0]         div_m   [0:2];

   logic [SB:0] csr_sz;
   logic [TB:0] csr_st;

   assign csr_ready = 1'b1;
   assign t_m1 = TB'(size_t_ff - 1'b1);
   assign csr_sz = csr_data[SB:0];
   assign csr_st = csr_data[TB:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) size_m1_ff[a] <= '1;
         size_t_ff  <= (TB+1)'(1 << TB);
         step_dt_ff <= DW'(6554);
      end else if (csr_valid) begin
         case (csr_index)
            vfs_pkg::CSR_SIZE_X, vfs_pkg::CSR_SIZE_Y, vfs_pkg::CSR_SIZE_Z: begin
               if (csr_sz == '0)
                  size_m1_ff[csr_index[1:0]] <= '0;
               else if (csr_sz > (SB+1)'(1 << SB))
                  size_m1_ff[csr_index[1:0]] <= '1;
               else
                  size_m1_ff[csr_index[1:0]] <= SB'(csr_sz - 1'b1);
            end
            vfs_pkg::CSR_SIZE_T: begin
               if (csr_st == '0)
                  size_t_ff <= (TB+1)'(1);
               else if (csr_st > (TB+1)'(1 << TB))
                  size_t_ff <= (TB+1)'(1 << TB);
               else
                  size_t_ff <= csr_st;
            end
            vfs_pkg::CSR_STEP_DT: begin
               step_dt_ff <= (csr_data > CSR_DATA_MAX) ? DW'(1 << FB) : csr_data[DW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // request unpacking
   assign req_pos[0] = req_tdata[PW-1:0];
   assign req_pos[1] = req_tdata[2*PW-1:PW];
   assign req_pos[2] = req_tdata[3*PW-1:2*PW];
   assign req_t      = req_tdata[3*PW+TW-1:3*PW];
   assign wr_addr    = {req_tdata[3*PW+TW+3*SB+TB-1:3*PW+TW+3*SB],
                        req_tdata[3*PW+TW+3*SB-1:3*PW+TW+2*SB],
                        req_tdata[3*PW+TW+2*SB-1:3*PW+TW+SB],
                        req_tdata[3*PW+TW+SB-1:3*PW+TW]};

   always_comb begin
      req_inb = ({1'b0, req_t} <= {size_t_ff, FB'(0)});
      for (int a = 0; a < 3; a++)
         if (req_pos[a] > {size_m1_ff[a], FB'(0)}) req_inb = 1'b0;
   end

   // neighbour indices, clamped to the sizes in use
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         base_idx[a] = (s_pos_ff[a][PW-1:FB] > size_m1_ff[a]) ? size_m1_ff[a]
                                                              : s_pos_ff[a][PW-1:FB];
         top_idx[a]  = (base_idx[a] == size_m1_ff[a]) ? base_idx[a] : SB'(base_idx[a] + 1'b1);
      end
      t_base = (s_t_ff[TW-1:FB] > t_m1) ? t_m1 : s_t_ff[TW-1:FB];
      t_top  = (t_base == t_m1) ? t_base : TB'(t_base + 1'b1);
      rd_addr = {cmd.slice ? t_top : t_base,
                 cmd.rd_idx[2] ? top_idx[2] : base_idx[2],
                 cmd.rd_idx[1] ? top_idx[1] : base_idx[1],
                 cmd.rd_idx[0] ? top_idx[0] : base_idx[0]};
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en)
         field_store_ff[wr_addr] <= req_tdata[3*PW+TW+3*SB+TB+vfs_pkg::VEC_W-1:
                                              3*PW+TW+3*SB+TB];
      if (cmd.rd_en)
         rdata_ff <= field_store_ff[rd_addr];
   end

   // lerp lanes, one per component
   always_comb begin
      case (cmd.lerp_step)
         vfs_pkg::LERP_X0, vfs_pkg::LERP_X1,
         vfs_pkg::LERP_X2, vfs_pkg::LERP_X3: lerp_f = s_pos_ff[0][FB-1:0];
         vfs_pkg::LERP_Y0, vfs_pkg::LERP_Y1: lerp_f = s_pos_ff[1][FB-1:0];
         vfs_pkg::LERP_Z:                    lerp_f = s_pos_ff[2][FB-1:0];
         default:                            lerp_f = s_t_ff[FB-1:0];
      endcase
      for (int c = 0; c < 3; c++) begin
         case (cmd.lerp_step)
            vfs_pkg::LERP_X0: begin lerp_a[c] = corner_ff[0][c]; lerp_b[c] = corner_ff[1][c]; end
            vfs_pkg::LERP_X1: begin lerp_a[c] = corner_ff[2][c]; lerp_b[c] = corner_ff[3][c]; end
            vfs_pkg::LERP_X2: begin lerp_a[c] = corner_ff[4][c]; lerp_b[c] = corner_ff[5][c]; end
            vfs_pkg::LERP_X3: begin lerp_a[c] = corner_ff[6][c]; lerp_b[c] = corner_ff[7][c]; end
            vfs_pkg::LERP_Y0: begin lerp_a[c] = corner_ff[0][c]; lerp_b[c] = corner_ff[2][c]; end
            vfs_pkg::LERP_Y1: begin lerp_a[c] = corner_ff[4][c]; lerp_b[c] = corner_ff[6][c]; end
            vfs_pkg::LERP_Z:  begin lerp_a[c] = corner_ff[0][c]; lerp_b[c] = corner_ff[4][c]; end
            default:          begin lerp_a[c] = slice_ff[0][c];  lerp_b[c] = slice_ff[1][c];  end
         endcase
         lerp_d[c] = (CW+1)'(lerp_b[c]) - (CW+1)'(lerp_a[c]);
         lerp_p[c] = LW'($signed({1'b0, lerp_f}) * lerp_d[c]);
         // round half up, then back to Q7.8
         lerp_r[c] = lerp_a[c] + CW'((lerp_p[c] + LW'(1 << (FB - 1))) >>> FB);
      end
   end

   // stage position and time update
   always_comb begin
      logic signed [MW-1:0] rnd;
      logic signed [NW-1:0] n;
      logic [DW-1:0]        dt_step;
      logic [TW:0]          tn;
      for (int a = 0; a < 3; a++) begin
         rnd = cmd.adv_half ? ((adv_prod_ff[a] + MW'(256)) >>> 9)
                            : ((adv_prod_ff[a] + MW'(128)) >>> 8);
         n = $signed({(NW-PW)'(0), q_pos_ff[a]}) + NW'(rnd);
         if (n[NW-1])
            adv_pos[a] = '0;
         else if (n > $signed({(NW-PW)'(0), size_m1_ff[a], FB'(0)}))
            adv_pos[a] = {size_m1_ff[a], FB'(0)};
         else
            adv_pos[a] = n[PW-1:0];
      end
      dt_step = cmd.adv_half ? DW'((DW+1)'(step_dt_ff + 1'b1) >> 1) : step_dt_ff;
      tn = (TW+1)'(q_t_ff) + (TW+1)'(dt_step);
      adv_t = (tn > (TW+1)'({t_m1, FB'(0)})) ? {t_m1, FB'(0)} : tn[TW-1:0];
      for (int c = 0; c < 3; c++)
         div_m[c] = AW'(acc_ff[c]) + ACC_BIAS;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int a = 0; a < 3; a++) begin
            q_pos_ff[a] <= req_pos[a];
            s_pos_ff[a] <= req_pos[a];
         end
         q_t_ff <= req_t;
         s_t_ff <= req_t;
         inb_ff <= req_inb;
      end else if (cmd.adv_upd) begin
         for (int a = 0; a < 3; a++) s_pos_ff[a] <= adv_pos[a];
         s_t_ff <= adv_t;
      end
      for (int c = 0; c < 3; c++) begin
         if (cmd.cap_en)
            corner_ff[cmd.cap_idx][c] <= rdata_ff[c*CW +: CW];
         if (cmd.lerp_en) begin
            case (cmd.lerp_step)
               vfs_pkg::LERP_X0, vfs_pkg::LERP_Y0: corner_ff[0][c] <= lerp_r[c];
               vfs_pkg::LERP_X1:                   corner_ff[2][c] <= lerp_r[c];
               vfs_pkg::LERP_X2, vfs_pkg::LERP_Y1: corner_ff[4][c] <= lerp_r[c];
               vfs_pkg::LERP_X3:                   corner_ff[6][c] <= lerp_r[c];
               vfs_pkg::LERP_Z:                    slice_ff[cmd.slice][c] <= lerp_r[c];
               default:                            vres_ff[c] <= lerp_r[c];
            endcase
         end
         if (cmd.acc_en)
            acc_ff[c] <= (cmd.acc_first ? AW'(3) : acc_ff[c]) +
                         (cmd.acc_double ? (AW'(vres_ff[c]) <<< 1) : AW'(vres_ff[c]));
         if (cmd.adv_mul)
            adv_prod_ff[c] <= MW'(vres_ff[c] * $signed({1'b0, step_dt_ff}));
         if (cmd.div_mul)
            div_prod_ff[c] <= QW'(div_m[c] * vfs_pkg::RECIP6);
         if (cmd.div_upd)
            // floor((sum + 3) / 6), offset removed by flipping the sign bit
            vres_ff[c] <= {~div_prod_ff[c][vfs_pkg::DIV_K+CW-1],
                           div_prod_ff[c][vfs_pkg::DIV_K+CW-2:vfs_pkg::DIV_K]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         out_vel_ff <= {vres_ff[2], vres_ff[1], vres_ff[0]};
         out_inb_ff <= inb_ff;
      end
   end

   assign status.out_free = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_vel_ff;
   assign rsp_tuser  = out_inb_ff;

endmodule

// File: hdl/vfs_ctrl.sv
// Controller: sequences corner reads, lerp steps, RK4 stages and result hand-off.
module vfs_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [vfs_pkg::KIND_W-1:0]    req_tuser,
   input  vfs_pkg::status_type           status,
   output vfs_pkg::cmd_type              cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_LERP, ST_TLERP, ST_ACCUM, ST_ADVANCE, ST_DIVMUL, ST_DIVOUT, ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [3:0]             cnt_ff, cnt_in;
   vfs_pkg::lerp_step_type step_ff, step_in;
   logic                   slice_ff, slice_in;
   logic [1:0]             stage_ff, stage_in;
   logic                   rk4_ff, rk4_in;
   logic                   accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      step_in  = step_ff;
      slice_in = slice_ff;
      stage_in = stage_ff;
      rk4_in   = rk4_ff;
      cmd      = '0;
      cmd.slice     = slice_ff;
      cmd.lerp_step = step_ff;
      cmd.rd_idx    = cnt_ff[2:0];
      cmd.cap_idx   = 3'(cnt_ff - 1'b1);
      cmd.adv_half  = (stage_ff != 2'd2);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.wr_en = (req_tuser == vfs_pkg::KIND_WRITE);
               if (req_tuser == vfs_pkg::KIND_SAMPLE || req_tuser == vfs_pkg::KIND_RK4) begin
                  cmd.load = 1'b1;
                  rk4_in   = (req_tuser == vfs_pkg::KIND_RK4);
                  stage_in = 2'd0;
                  slice_in = 1'b0;
                  cnt_in   = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            // read pipeline: issue corner cnt, capture corner cnt-1
            cmd.rd_en  = (cnt_ff[3] == 1'b0);
            cmd.cap_en = (cnt_ff != '0);
            if (cnt_ff[3]) begin
               step_in  = vfs_pkg::LERP_X0;
               state_in = ST_LERP;
            end else begin
               cnt_in = 4'(cnt_ff + 1'b1);
            end
         end
         ST_LERP: begin
            cmd.lerp_en = 1'b1;
            if (step_ff == vfs_pkg::LERP_Z) begin
               cnt_in = '0;
               if (!slice_ff) begin
                  slice_in = 1'b1;
                  state_in = ST_READ;
               end else begin
                  step_in  = vfs_pkg::LERP_T;
                  state_in = ST_TLERP;
               end
            end else begin
               step_in = vfs_pkg::lerp_step_type'(step_ff + 1'b1);
            end
         end
         ST_TLERP: begin
            cmd.lerp_en = 1'b1;
            state_in = rk4_ff ? ST_ACCUM : ST_DONE;
         end
         ST_ACCUM: begin
            cmd.acc_en     = 1'b1;
            cmd.acc_first  = (stage_ff == 2'd0);
            cmd.acc_double = (stage_ff == 2'd1) || (stage_ff == 2'd2);
            cmd.adv_mul    = 1'b1;
            state_in = (stage_ff == 2'd3) ? ST_DIVMUL : ST_ADVANCE;
         end
         ST_ADVANCE: begin
            cmd.adv_upd = 1'b1;
            stage_in = 2'(stage_ff + 1'b1);
            slice_in = 1'b0;
            cnt_in   = '0;
            state_in = ST_READ;
         end
         ST_DIVMUL: begin
            cmd.div_mul = 1'b1;
            state_in = ST_DIVOUT;
         end
         ST_DIVOUT: begin
            cmd.div_upd = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the result register frees up
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         step_ff  <= vfs_pkg::LERP_X0;
         slice_ff <= 1'b0;
         stage_ff <= 2'd0;
         rk4_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         step_ff  <= step_in;
         slice_ff <= slice_in;
         stage_ff <= stage_in;
         rk4_ff   <= rk4_in;
      end
   end

`ifndef SYNTH
   a_no_rd_lerp_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_en && cmd.lerp_en)) else $error("read and lerp issued together");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (cnt_ff <= 4'd8)) else $error("read counter overran");
   a_load_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (state_ff == ST_IDLE)) else $error("no return to idle after result");
   a_stage_only_rk4: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCUM) |-> rk4_ff) else $error("rk4 accumulate on a plain sample");
   a_adv_after_accum: assert property (@(posedge clock) disable iff (reset)
      cmd.adv_upd |-> $past(cmd.adv_mul)) else $error("advance without product");
`endif

endmodule

// File: hdl/vector_field_sampler_rk4.sv
// Time-varying 3D vector field sampler: a write beat stores one voxel;
// a sample beat runs two time slices of eight voxel reads through the one
// field memory port plus seven lerp steps each, then a time lerp and the result hand-off;
// an rk4 beat runs four samples, the stage position updates and the divide by six.
// One beat is processed at a time; the next is taken while a result waits.
module vector_field_sampler_rk4 (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // pos_x, pos_y, pos_z, pos_t, cell_x, cell_y, cell_z, cell_t, val_x, val_y, val_z, pad
   input  logic [vfs_pkg::REQ_DATA_W-1:0]  req_tdata,
   // kind
   input  logic [vfs_pkg::KIND_W-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // vel_x, vel_y, vel_z
   output logic [vfs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // in_bounds
   output logic                            rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [vfs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vfs_pkg::CSR_DATA_W-1:0]  csr_data
);

   vfs_pkg::cmd_type    cmd;
   vfs_pkg::status_type status;

   vfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   vfs_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
